### sv/cscs_pkg.sv
// Shared types, constants and helpers of the clocked serial command sender.
`timescale 1ns / 1ps
`default_nettype none

package cscs_pkg;

   // Fixed field and register widths
   localparam int CmdWidth       = 16;
   localparam int CountWidth     = 24;
   localparam int TickWidth      = 16;
   localparam int CsrAddrWidth   = 4;
   localparam int CsrDataWidth   = 32;
   localparam int QueueDepth     = 2;

   // Register reset values
   localparam logic [CountWidth-1:0] ResetTicksDefault   = 24'd4864000;
   localparam logic [TickWidth-1:0]  StartTicksDefault   = 16'd32000;
   localparam logic [TickWidth-1:0]  HalfPeriodDefault   = 16'd2000;
   localparam logic [TickWidth-1:0]  TimeoutTicksDefault = 16'd32000;

   // Register map, word index
   typedef enum logic [1:0] {
      REG_RESET_TICKS       = 2'd0,
      REG_START_TICKS       = 2'd1,
      REG_HALF_PERIOD_TICKS = 2'd2,
      REG_TIMEOUT_TICKS     = 2'd3
   } reg_index_type;

   // Item classification
   typedef enum logic [0:0] {
      ITEM_TICK = 1'b0,
      ITEM_SEND = 1'b1
   } item_kind_type;

   // Sequencer phases, one-hot
   typedef enum logic [5:0] {
      PH_RESET_WAIT = 6'b000001,
      PH_IDLE       = 6'b000010,
      PH_START      = 6'b000100,
      PH_CLOCK      = 6'b001000,
      PH_STOP       = 6'b010000,
      PH_TIMEOUT    = 6'b100000
   } phase_type;

   // Configuration as seen by the sequencer
   typedef struct packed {
      logic [CountWidth-1:0] reset_ticks;
      logic [TickWidth-1:0]  start_ticks;
      logic [TickWidth-1:0]  half_period_ticks;
      logic [TickWidth-1:0]  timeout_ticks;
      logic                  reset_ticks_wr;
   } cfg_type;

   // A zero interval counts as one tick
   function automatic logic [CountWidth-1:0] load_count(input logic [CountWidth-1:0] v);
      logic [CountWidth-1:0] r;
      r = (v == '0) ? CountWidth'(1) : v;
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/cscs_csr.sv
// Configuration registers of the serial command sender behind an APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module cscs_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [cscs_pkg::CsrAddrWidth-1:0]  paddr,
   input  wire logic [cscs_pkg::CsrDataWidth-1:0]  pwdata,
   output logic      [cscs_pkg::CsrDataWidth-1:0]  prdata,
   output logic                                    pready,
   output cscs_pkg::cfg_type                       cfg
);

   logic [cscs_pkg::CountWidth-1:0] reset_ticks_ff, reset_ticks_in;
   logic [cscs_pkg::TickWidth-1:0]  start_ticks_ff, start_ticks_in;
   logic [cscs_pkg::TickWidth-1:0]  half_period_ff, half_period_in;
   logic [cscs_pkg::TickWidth-1:0]  timeout_ticks_ff, timeout_ticks_in;
   logic                            reset_wr;
   logic                            wr;
   cscs_pkg::reg_index_type         idx;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign idx    = cscs_pkg::reg_index_type'(paddr[3:2]);

   // Write decode
   always_comb begin
      reset_ticks_in   = reset_ticks_ff;
      start_ticks_in   = start_ticks_ff;
      half_period_in   = half_period_ff;
      timeout_ticks_in = timeout_ticks_ff;
      reset_wr         = 1'b0;
      if (wr) begin
         unique case (idx)
            cscs_pkg::REG_RESET_TICKS: begin
               reset_ticks_in = pwdata[cscs_pkg::CountWidth-1:0];
               reset_wr       = 1'b1;
            end
            cscs_pkg::REG_START_TICKS:       start_ticks_in   = pwdata[cscs_pkg::TickWidth-1:0];
            cscs_pkg::REG_HALF_PERIOD_TICKS: half_period_in   = pwdata[cscs_pkg::TickWidth-1:0];
            cscs_pkg::REG_TIMEOUT_TICKS:     timeout_ticks_in = pwdata[cscs_pkg::TickWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_ticks_ff   <= cscs_pkg::ResetTicksDefault;
         start_ticks_ff   <= cscs_pkg::StartTicksDefault;
         half_period_ff   <= cscs_pkg::HalfPeriodDefault;
         timeout_ticks_ff <= cscs_pkg::TimeoutTicksDefault;
      end else begin
         reset_ticks_ff   <= reset_ticks_in;
         start_ticks_ff   <= start_ticks_in;
         half_period_ff   <= half_period_in;
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         cscs_pkg::REG_RESET_TICKS:       prdata = cscs_pkg::CsrDataWidth'(reset_ticks_ff);
         cscs_pkg::REG_START_TICKS:       prdata = cscs_pkg::CsrDataWidth'(start_ticks_ff);
         cscs_pkg::REG_HALF_PERIOD_TICKS: prdata = cscs_pkg::CsrDataWidth'(half_period_ff);
         cscs_pkg::REG_TIMEOUT_TICKS:     prdata = cscs_pkg::CsrDataWidth'(timeout_ticks_ff);
         default:                         prdata = '0;
      endcase
   end

   // The reload strobe carries the value that is being written
   always_comb begin
      cfg.reset_ticks       = reset_wr ? reset_ticks_in : reset_ticks_ff;
      cfg.start_ticks       = start_ticks_ff;
      cfg.half_period_ticks = half_period_ff;
      cfg.timeout_ticks     = timeout_ticks_ff;
      cfg.reset_ticks_wr    = reset_wr;
   end

endmodule

`default_nettype wire

### sv/cscs_front.sv
// Front end: takes request transactions, classifies them and stages them for the queue.
`timescale 1ns / 1ps
`default_nettype none

module cscs_front #(
   parameter int COMMAND_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_op,
   input  wire logic [cscs_pkg::CmdWidth-1:0]     req_command,
   output logic                                   push_valid,
   input  wire logic                              push_ready,
   output logic      [COMMAND_BITS:0]             push_data
);

   logic                                     valid_ff, valid_in;
   cscs_pkg::item_kind_type                  kind_ff, kind_in;
   logic [COMMAND_BITS-1:0]                  word_ff, word_in;
   logic [cscs_pkg::CmdWidth+COMMAND_BITS-1:0] cmd_ext;
   logic                                     take;

   assign req_ready  = ~valid_ff | push_ready;
   assign take       = req_valid & req_ready;
   assign push_valid = valid_ff;
   assign push_data  = {kind_ff, word_ff};

   // Fit the command to the word length of the shifter
   assign cmd_ext = {{COMMAND_BITS{1'b0}}, req_command};

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      word_in  = word_ff;
      if (take) begin
         valid_in = 1'b1;
         kind_in  = req_op ? cscs_pkg::ITEM_SEND : cscs_pkg::ITEM_TICK;
         word_in  = cmd_ext[COMMAND_BITS-1:0];
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      kind_ff <= kind_in;
      word_ff <= word_in;
   end

endmodule

`default_nettype wire

### sv/cscs_queue.sv
// Short register queue between the front end and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module cscs_queue #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  push, pop;

   assign push_ready = (count_ff != CountWidth'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Fill level never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH))
      else $error("queue fill level beyond depth");

endmodule

`default_nettype wire

### sv/cscs_back.sv
// Back end: the line sequencer that runs ticks and sends, with the result register.
`timescale 1ns / 1ps
`default_nettype none

module cscs_back #(
   parameter int COMMAND_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cscs_pkg::cfg_type       cfg,
   input  wire logic                    item_valid,
   output logic                         item_pop,
   input  wire logic [COMMAND_BITS:0]   item_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_clock_line,
   output logic                         rsp_data_line,
   output logic                         rsp_ready_res,
   output logic                         rsp_accepted
);

   localparam int BitIdxWidth = $clog2(COMMAND_BITS);
   localparam logic [BitIdxWidth-1:0] TopBit = BitIdxWidth'(COMMAND_BITS - 1);
   localparam int CW = cscs_pkg::CountWidth;

   cscs_pkg::phase_type     phase_ff, phase_in;
   logic [CW-1:0]           countdown_ff, countdown_in;
   logic [COMMAND_BITS-1:0] word_ff, word_in;
   logic [BitIdxWidth-1:0]  bit_index_ff, bit_index_in;
   logic                    high_phase_ff, high_phase_in;
   logic                    clock_level_ff, clock_level_in;
   logic                    data_level_ff, data_level_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_clock_ff, rsp_data_ff, rsp_idle_ff, rsp_took_ff;
   logic                    took;

   cscs_pkg::item_kind_type kind;
   logic [COMMAND_BITS-1:0] item_word;
   logic [CW-1:0]           count_dec;
   logic [BitIdxWidth-1:0]  bit_dec;

   assign kind      = cscs_pkg::item_kind_type'(item_data[COMMAND_BITS]);
   assign item_word = item_data[COMMAND_BITS-1:0];
   assign item_pop  = item_valid & (~rsp_valid_ff | rsp_ready);
   assign count_dec = (countdown_ff == '0) ? '0 : countdown_ff - 1'b1;
   assign bit_dec   = (bit_index_ff != '0) ? bit_index_ff - 1'b1 : bit_index_ff;

   // Sequencer next state
   always_comb begin
      phase_in       = phase_ff;
      countdown_in   = countdown_ff;
      word_in        = word_ff;
      bit_index_in   = bit_index_ff;
      high_phase_in  = high_phase_ff;
      clock_level_in = clock_level_ff;
      data_level_in  = data_level_ff;
      took           = 1'b0;
      if (item_pop) begin
         if (kind == cscs_pkg::ITEM_SEND) begin
            // send is taken only while idle, otherwise dropped
            if (phase_ff == cscs_pkg::PH_IDLE) begin
               word_in        = item_word;
               bit_index_in   = TopBit;
               high_phase_in  = 1'b0;
               clock_level_in = 1'b0;
               data_level_in  = item_word[TopBit];
               countdown_in   = cscs_pkg::load_count(CW'(cfg.start_ticks));
               phase_in       = cscs_pkg::PH_START;
               took           = 1'b1;
            end
         end else if (phase_ff != cscs_pkg::PH_IDLE) begin
            countdown_in = count_dec;
            if (count_dec == '0) begin
               unique case (phase_ff)
                  cscs_pkg::PH_RESET_WAIT: phase_in = cscs_pkg::PH_IDLE;
                  cscs_pkg::PH_START: begin
                     countdown_in  = cscs_pkg::load_count(CW'(cfg.half_period_ticks));
                     bit_index_in  = TopBit;
                     high_phase_in = 1'b0;
                     phase_in      = cscs_pkg::PH_CLOCK;
                  end
                  cscs_pkg::PH_CLOCK: begin
                     countdown_in   = cscs_pkg::load_count(CW'(cfg.half_period_ticks));
                     clock_level_in = ~clock_level_ff;
                     high_phase_in  = ~high_phase_ff;
                     // falling edge: present the next lower bit
                     if (high_phase_ff) begin
                        bit_index_in  = bit_dec;
                        data_level_in = word_ff[bit_dec];
                        if (bit_dec == '0) begin
                           phase_in = cscs_pkg::PH_STOP;
                        end
                     end
                  end
                  cscs_pkg::PH_STOP: begin
                     clock_level_in = 1'b1;
                     countdown_in   = cscs_pkg::load_count(CW'(cfg.timeout_ticks));
                     phase_in       = cscs_pkg::PH_TIMEOUT;
                  end
                  default: phase_in = cscs_pkg::PH_IDLE;
               endcase
            end
         end
      end
      // new reset wait length restarts the wait
      if (cfg.reset_ticks_wr && phase_ff == cscs_pkg::PH_RESET_WAIT) begin
         countdown_in = cscs_pkg::load_count(cfg.reset_ticks);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= cscs_pkg::PH_RESET_WAIT;
         countdown_ff   <= cscs_pkg::load_count(cscs_pkg::ResetTicksDefault);
         word_ff        <= '0;
         bit_index_ff   <= TopBit;
         high_phase_ff  <= 1'b0;
         clock_level_ff <= 1'b1;
         data_level_ff  <= 1'b1;
      end else begin
         phase_ff       <= phase_in;
         countdown_ff   <= countdown_in;
         word_ff        <= word_in;
         bit_index_ff   <= bit_index_in;
         high_phase_ff  <= high_phase_in;
         clock_level_ff <= clock_level_in;
         data_level_ff  <= data_level_in;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (item_pop) begin
         rsp_clock_ff <= clock_level_in;
         rsp_data_ff  <= data_level_in;
         rsp_idle_ff  <= (phase_in == cscs_pkg::PH_IDLE);
         rsp_took_ff  <= took;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_clock_line = rsp_clock_ff;
   assign rsp_data_line  = rsp_data_ff;
   assign rsp_ready_res  = rsp_idle_ff;
   assign rsp_accepted   = rsp_took_ff;

   // A taken send pulls the clock low and leaves idle
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_took_ff) |-> (!rsp_idle_ff && !rsp_clock_ff))
      else $error("accepted send did not start a frame");

   // The clock line rests high whenever idle
   a_idle_clock_high: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == cscs_pkg::PH_IDLE) |-> clock_level_ff)
      else $error("clock line low while idle");

   // Shifting leaves for stop as soon as bit 0 is out
   a_clock_bit_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == cscs_pkg::PH_CLOCK) |-> (bit_index_ff != '0))
      else $error("clock phase with no bits left");

endmodule

`default_nettype wire

### sv/clocked_serial_command_sender.sv
// Top level of the two-wire clocked serial command sender.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   req_op, req_command
//   rsp_      out        rsp_valid/rsp_ready   rsp_clock_line, rsp_data_line,
//                                              rsp_ready_res, rsp_accepted
//   csr_      in         APB-style, pready=1   reset/start/half period/timeout ticks
//
// One request transaction per clock sustained while rsp_ready stays high; each
// yields one response, registered in the front register, queue and result register.
// The sequencer updates its countdown and line state from each item it pops.
// Reset is synchronous; afterwards the sequencer waits reset_ticks tick items.
// Response stalls back up into a two-entry queue and then the front register.
`timescale 1ns / 1ps
`default_nettype none

module clocked_serial_command_sender #(
   parameter int COMMAND_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_op,
   input  wire logic [cscs_pkg::CmdWidth-1:0]         req_command,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_clock_line,
   output logic                                       rsp_data_line,
   output logic                                       rsp_ready_res,
   output logic                                       rsp_accepted,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [cscs_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  wire logic [cscs_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic      [cscs_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                       csr_pready
);

   cscs_pkg::cfg_type       cfg;
   logic                    push_valid, push_ready;
   logic [COMMAND_BITS:0]   push_data;
   logic                    item_valid, item_pop;
   logic [COMMAND_BITS:0]   item_data;

   cscs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   cscs_front #(.COMMAND_BITS(COMMAND_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_command (req_command),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   cscs_queue #(.WIDTH(COMMAND_BITS + 1), .DEPTH(cscs_pkg::QueueDepth)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (item_valid),
      .pop_ready  (item_pop),
      .pop_data   (item_data)
   );

   cscs_back #(.COMMAND_BITS(COMMAND_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .item_valid     (item_valid),
      .item_pop       (item_pop),
      .item_data      (item_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_clock_line (rsp_clock_line),
      .rsp_data_line  (rsp_data_line),
      .rsp_ready_res  (rsp_ready_res),
      .rsp_accepted   (rsp_accepted)
   );

endmodule

`default_nettype wire

### bench/tb_clocked_serial_command_sender.sv
// Self-checking testbench for the clocked serial command sender.
`timescale 1ns / 1ps

module tb_clocked_serial_command_sender;

   localparam int CmdWidth     = cscs_pkg::CmdWidth;
   localparam int CountWidth   = cscs_pkg::CountWidth;
   localparam int TickWidth    = cscs_pkg::TickWidth;
   localparam int CsrAddrWidth = cscs_pkg::CsrAddrWidth;
   localparam int CsrDataWidth = cscs_pkg::CsrDataWidth;

   localparam int WatchdogLimit = 400;
   localparam int RandomPhases  = 6;
   localparam int PhaseItems    = 160;
   localparam int LongRunTicks  = 100;
   localparam logic [CountWidth-1:0] MaxResetTicks = '1;
   localparam logic [TickWidth-1:0]  MaxTicks      = '1;

   // Pin levels carried by one response transaction
   typedef struct packed {
      logic clock_line;
      logic data_line;
      logic ready_res;
      logic accepted;
   } line_levels_type;

   // Scoreboard: own copy of the sequencer and the queue of expected pin levels
   class serial_levels_scoreboard;
      logic [CountWidth-1:0] reset_ticks;
      logic [TickWidth-1:0]  start_ticks;
      logic [TickWidth-1:0]  half_period_ticks;
      logic [TickWidth-1:0]  timeout_ticks;

      cscs_pkg::phase_type   phase;
      logic [CountWidth-1:0] countdown;
      logic [CmdWidth-1:0]   shift_word;
      logic [4:0]            bit_index;
      logic                  clock_high_phase;
      logic                  clock_level;
      logic                  data_level;

      line_levels_type expected_levels[$];
      int responses_checked;
      int sends_taken;
      int sends_refused;
      int mismatches;

      // Zero-length intervals last one tick
      function logic [CountWidth-1:0] interval_of(logic [CountWidth-1:0] ticks);
         return (ticks == '0) ? CountWidth'(1) : ticks;
      endfunction

      function new();
         reset_ticks       = cscs_pkg::ResetTicksDefault;
         start_ticks       = cscs_pkg::StartTicksDefault;
         half_period_ticks = cscs_pkg::HalfPeriodDefault;
         timeout_ticks     = cscs_pkg::TimeoutTicksDefault;
         phase             = cscs_pkg::PH_RESET_WAIT;
         countdown         = interval_of(reset_ticks);
         shift_word        = '0;
         bit_index         = 5'(CmdWidth - 1);
         clock_high_phase  = 1'b0;
         clock_level       = 1'b1;
         data_level        = 1'b1;
      endfunction

      function bit is_idle();
         return phase == cscs_pkg::PH_IDLE;
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      function void write_reg(cscs_pkg::reg_index_type idx, logic [CsrDataWidth-1:0] value);
         case (idx)
            cscs_pkg::REG_RESET_TICKS: begin
               reset_ticks = value[CountWidth-1:0];
               // a new wait length restarts the post-reset wait
               if (phase == cscs_pkg::PH_RESET_WAIT) countdown = interval_of(reset_ticks);
            end
            cscs_pkg::REG_START_TICKS:       start_ticks       = value[TickWidth-1:0];
            cscs_pkg::REG_HALF_PERIOD_TICKS: half_period_ticks = value[TickWidth-1:0];
            cscs_pkg::REG_TIMEOUT_TICKS:     timeout_ticks     = value[TickWidth-1:0];
            default: ;
         endcase
      endfunction

      // Action at the end of a timed interval
      function void end_of_interval();
         case (phase)
            cscs_pkg::PH_RESET_WAIT: phase = cscs_pkg::PH_IDLE;
            cscs_pkg::PH_START: begin
               countdown        = interval_of(CountWidth'(half_period_ticks));
               bit_index        = 5'(CmdWidth - 1);
               clock_high_phase = 1'b0;
               phase            = cscs_pkg::PH_CLOCK;
            end
            cscs_pkg::PH_CLOCK: begin
               countdown   = interval_of(CountWidth'(half_period_ticks));
               clock_level = ~clock_level;
               if (clock_high_phase) begin
                  // falling edge: next lower bit
                  clock_high_phase = 1'b0;
                  if (bit_index > 0) bit_index = bit_index - 1'b1;
                  data_level = shift_word[bit_index[3:0]];
                  if (bit_index == 0) phase = cscs_pkg::PH_STOP;
               end else begin
                  clock_high_phase = 1'b1;
               end
            end
            cscs_pkg::PH_STOP: begin
               clock_level = 1'b1;
               countdown   = interval_of(CountWidth'(timeout_ticks));
               phase       = cscs_pkg::PH_TIMEOUT;
            end
            default: phase = cscs_pkg::PH_IDLE;
         endcase
      endfunction

      // Accepted request transaction: advance the copy and queue its levels
      function void note_request(cscs_pkg::item_kind_type kind, logic [CmdWidth-1:0] command);
         line_levels_type levels;
         levels.accepted = 1'b0;
         if (kind == cscs_pkg::ITEM_SEND) begin
            if (phase == cscs_pkg::PH_IDLE) begin
               shift_word       = command;
               bit_index        = 5'(CmdWidth - 1);
               clock_high_phase = 1'b0;
               clock_level      = 1'b0;
               data_level       = command[CmdWidth-1];
               countdown        = interval_of(CountWidth'(start_ticks));
               phase            = cscs_pkg::PH_START;
               levels.accepted  = 1'b1;
               sends_taken++;
            end else begin
               sends_refused++;
            end
         end else if (phase != cscs_pkg::PH_IDLE) begin
            if (countdown > 0) countdown = countdown - 1'b1;
            if (countdown == 0) end_of_interval();
         end
         levels.clock_line = clock_level;
         levels.data_line  = data_level;
         levels.ready_res  = (phase == cscs_pkg::PH_IDLE);
         expected_levels.push_back(levels);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("[%0t] response %0d: %s", $realtime, responses_checked, what);
      endtask

      // Accepted response transaction: compare with the oldest expectation
      task check_response(line_levels_type got);
         line_levels_type want;
         if (expected_levels.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = expected_levels.pop_front();
            if (got.clock_line !== want.clock_line)
               report_mismatch($sformatf("clock_line %b, expected %b",
                                         got.clock_line, want.clock_line));
            if (got.data_line !== want.data_line)
               report_mismatch($sformatf("data_line %b, expected %b",
                                         got.data_line, want.data_line));
            if (got.ready_res !== want.ready_res)
               report_mismatch($sformatf("ready_res %b, expected %b",
                                         got.ready_res, want.ready_res));
            if (got.accepted !== want.accepted)
               report_mismatch($sformatf("accepted %b, expected %b",
                                         got.accepted, want.accepted));
         end
         responses_checked++;
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_op;
   logic [CmdWidth-1:0]     req_command;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_clock_line;
   logic                    rsp_data_line;
   logic                    rsp_ready_res;
   logic                    rsp_accepted;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   serial_levels_scoreboard sb = new();
   int idle_odds;        // a burst starts with odds of one in idle_odds; 0 switches idling off
   int rsp_stall_left;
   int quiet_cycles;

   clocked_serial_command_sender DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_command    (req_command),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_clock_line (rsp_clock_line),
      .rsp_data_line  (rsp_data_line),
      .rsp_ready_res  (rsp_ready_res),
      .rsp_accepted   (rsp_accepted),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Monitor both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(cscs_pkg::item_kind_type'(req_op), req_command);
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_clock_line, rsp_data_line, rsp_ready_res, rsp_accepted});
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WatchdogLimit) begin
            $display("Watchdog: no transaction for %0d cycles", WatchdogLimit);
            $display("clocked_serial_command_sender test failed");
            $finish;
         end
      end
   end

   // Response back-pressure in random bursts
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready      <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
         rsp_stall_left <= $urandom_range(12, 0);
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // One request transaction; called and returns at a falling edge
   task drive_item(cscs_pkg::item_kind_type kind, logic [CmdWidth-1:0] command);
      if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(13, 1)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= kind;
      req_command <= command;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task tick_until_idle();
      while (!sb.is_idle())
         drive_item(cscs_pkg::ITEM_TICK, CmdWidth'($urandom_range(16'hFFFF, 0)));
   endtask

   // Let every outstanding response arrive with the request channel idle
   task drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register write: setup then access; pready is sampled at the rising edge
   task write_reg(cscs_pkg::reg_index_type idx, logic [CsrDataWidth-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task write_intervals(logic [CountWidth-1:0] rst_t, logic [TickWidth-1:0] start_t,
                        logic [TickWidth-1:0] half_t, logic [TickWidth-1:0] guard_t);
      write_reg(cscs_pkg::REG_RESET_TICKS, CsrDataWidth'(rst_t));
      write_reg(cscs_pkg::REG_START_TICKS, CsrDataWidth'(start_t));
      write_reg(cscs_pkg::REG_HALF_PERIOD_TICKS, CsrDataWidth'(half_t));
      write_reg(cscs_pkg::REG_TIMEOUT_TICKS, CsrDataWidth'(guard_t));
   endtask

   initial begin
      int items;
      logic [CmdWidth-1:0] command;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = 1'b0;
      req_command    = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      idle_odds      = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: longest reset wait, send refused during it
      write_reg(cscs_pkg::REG_RESET_TICKS, CsrDataWidth'(MaxResetTicks));
      drive_item(cscs_pkg::ITEM_TICK, 16'h0000);
      drive_item(cscs_pkg::ITEM_TICK, 16'hFFFF);
      drive_item(cscs_pkg::ITEM_SEND, 16'hFFFF);
      drive_item(cscs_pkg::ITEM_TICK, 16'h0000);
      drain();
      // zero intervals count as one tick; new reset length restarts the wait
      write_intervals('0, '0, '0, '0);
      drive_item(cscs_pkg::ITEM_TICK, 16'h0000);
      drive_item(cscs_pkg::ITEM_TICK, 16'h1234);      // tick while idle
      drive_item(cscs_pkg::ITEM_SEND, 16'h8000);
      drive_item(cscs_pkg::ITEM_SEND, 16'hFFFF);      // refused while busy
      tick_until_idle();
      drive_item(cscs_pkg::ITEM_SEND, 16'hFFFF);
      tick_until_idle();
      drive_item(cscs_pkg::ITEM_SEND, 16'h0001);
      drive_item(cscs_pkg::ITEM_TICK, 16'h0000);
      drain();

      // Random phases with short intervals; writes may land mid-send
      for (int p = 0; p < RandomPhases; p++) begin
         drain();
         write_intervals(CountWidth'($urandom), TickWidth'($urandom_range(4, 0)),
                         TickWidth'($urandom_range(3, 0)), TickWidth'($urandom_range(6, 0)));
         idle_odds = (p % 3 == 0) ? 0 : $urandom_range(12, 3);
         items = 0;
         while (items < PhaseItems) begin
            case ($urandom_range(3, 0))
               0:       command = 16'h0000;
               1:       command = 16'hFFFF;
               default: command = CmdWidth'($urandom_range(16'hFFFF, 0));
            endcase
            if (sb.is_idle()) begin
               if ($urandom_range(9, 0) < 7) drive_item(cscs_pkg::ITEM_SEND, command);
               else                          drive_item(cscs_pkg::ITEM_TICK, command);
               items++;
            end else if ($urandom_range(19, 0) == 0) begin
               drive_item(cscs_pkg::ITEM_SEND, command);   // noise, refused
            end else begin
               drive_item(cscs_pkg::ITEM_TICK, command);
               items++;
            end
         end
      end

      // Last part, no idling: longest intervals, start interval counts down from the top
      idle_odds = 0;
      tick_until_idle();
      drain();
      write_intervals(MaxResetTicks, MaxTicks, MaxTicks, MaxTicks);
      drive_item(cscs_pkg::ITEM_SEND, CmdWidth'($urandom_range(16'hFFFF, 0)));
      repeat (LongRunTicks)
         drive_item(cscs_pkg::ITEM_TICK, CmdWidth'($urandom_range(16'hFFFF, 0)));

      drain();
      repeat (8) @(negedge clock);
      $display("Checked %0d responses: %0d commands shifted out, %0d sends refused as busy.",
               sb.responses_checked, sb.sends_taken, sb.sends_refused);
      $display("Intervals from zero up to full width; reset wait restarted; random stalls.");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("clocked_serial_command_sender test passed");
      end else begin
         $display("clocked_serial_command_sender test failed");
      end
      $finish;
   end

endmodule

### filelist.f
sv/cscs_pkg.sv
sv/cscs_csr.sv
sv/cscs_front.sv
sv/cscs_queue.sv
sv/cscs_back.sv
sv/clocked_serial_command_sender.sv
bench/tb_clocked_serial_command_sender.sv
